### src/wake_on_radio_uplink_handshake_defines.svh
// Assertion macros for the wake-on-radio uplink handshake controller.
// Used by the checker; the enclosing scope must provide clock and reset.
`ifndef WAKE_ON_RADIO_UPLINK_HANDSHAKE_DEFINES_SVH
`define WAKE_ON_RADIO_UPLINK_HANDSHAKE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WOR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wor_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define WOR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wor_checker: next-cycle property failed");

`endif

### src/wor_pkg.sv
// Shared types and codes of the wake-on-radio uplink handshake controller.
// No dependencies; the step, queue, top-level and checker files import this package.
package wor_pkg;

   localparam int MAX_RES = 3;
   localparam int ID_SHIFT = 8;

   // Event codes carried by req_type.
   localparam logic [2:0] EV_TICK        = 3'd0;
   localparam logic [2:0] EV_TX_DONE     = 3'd1;
   localparam logic [2:0] EV_TX_TIMEOUT  = 3'd2;
   localparam logic [2:0] EV_RX_FRAME    = 3'd3;
   localparam logic [2:0] EV_RX_TIMEOUT  = 3'd4;
   localparam logic [2:0] EV_RX_ERROR    = 3'd5;
   localparam logic [2:0] EV_REPLY_TIMER = 3'd6;

   // Action codes of a result.
   localparam logic [2:0] ACT_SLEEP  = 3'd0;
   localparam logic [2:0] ACT_WAKE   = 3'd1;
   localparam logic [2:0] ACT_DATA   = 3'd2;
   localparam logic [2:0] ACT_ARM    = 3'd3;
   localparam logic [2:0] ACT_LISTEN = 3'd4;
   localparam logic [2:0] ACT_NOTICE = 3'd5;

   localparam logic [1:0] NOTE_NONE      = 2'd0;
   localparam logic [1:0] NOTE_SKIPPED   = 2'd1;
   localparam logic [1:0] NOTE_DISCARDED = 2'd2;

   localparam logic [1:0] KIND_WAKE      = 2'd0;
   localparam logic       DIR_UPSTREAM   = 1'b0;
   localparam logic [1:0] NODE_REPEATER  = 2'd1;
   localparam logic [1:0] NODE_GATEWAY   = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE_ID  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_DISTANCE = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_TXWAKE = 4'b0010,
      PH_WAIT   = 4'b0100,
      PH_TXDATA = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        retry_used;
      logic [7:0]  upstream_id;
      logic [7:0]  upstream_distance;
      logic [1:0]  upstream_type;
      logic [7:0]  seq_num;
      logic [15:0] data_count;
      logic        active;
   } state_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       queue_full;
      logic       rx_header_ok;
      logic [1:0] rx_packet_kind;
      logic       rx_direction;
      logic [1:0] rx_sender_type;
      logic [7:0] rx_sender_id;
      logic [7:0] rx_sender_distance;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  notice_code;
      logic [7:0]  dest_node_id;
      logic [1:0]  dest_node_type;
      logic [7:0]  dest_distance;
      logic [15:0] frame_id;
      logic [15:0] data_number;
      logic        cycle_active;
      logic        last;
   } rsp_entry_type;

   function automatic rsp_entry_type mk_entry(input logic [2:0] act, input logic [1:0] note,
                                              input logic [7:0] id, input logic [1:0] typ,
                                              input logic [7:0] node_dist,
                                              input logic [15:0] fid);
      rsp_entry_type e;
      e                = '0;
      e.action         = act;
      e.notice_code    = note;
      e.dest_node_id   = id;
      e.dest_node_type = typ;
      e.dest_distance  = node_dist;
      e.frame_id       = fid;
      return e;
   endfunction

endpackage

### src/wor_if.sv
// Valid/ready channel interfaces for event transactions and result transactions.
// Plain signal bundles; no package dependency.
interface wor_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic       queue_full;
   logic       rx_header_ok;
   logic [1:0] rx_packet_kind;
   logic       rx_direction;
   logic [1:0] rx_sender_type;
   logic [7:0] rx_sender_id;
   logic [7:0] rx_sender_distance;

   modport source(output valid, output req_type, output queue_full, output rx_header_ok,
                  output rx_packet_kind, output rx_direction, output rx_sender_type,
                  output rx_sender_id, output rx_sender_distance, input ready);
   modport sink(input valid, input req_type, input queue_full, input rx_header_ok,
                input rx_packet_kind, input rx_direction, input rx_sender_type,
                input rx_sender_id, input rx_sender_distance, output ready);
endinterface

interface wor_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [1:0]  notice_code;
   logic [7:0]  dest_node_id;
   logic [1:0]  dest_node_type;
   logic [7:0]  dest_distance;
   logic [15:0] frame_id;
   logic [15:0] data_number;
   logic        cycle_active;
   logic        last;

   modport source(output valid, output action, output notice_code, output dest_node_id,
                  output dest_node_type, output dest_distance, output frame_id,
                  output data_number, output cycle_active, output last, input ready);
   modport sink(input valid, input action, input notice_code, input dest_node_id,
                input dest_node_type, input dest_distance, input frame_id,
                input data_number, input cycle_active, input last, output ready);
endinterface

### src/wor_step.sv
// Next-state and result logic for one event of the uplink handshake.
// Depends on wor_pkg for the state, event and result types.
module wor_step
   import wor_pkg::*;
(
   input  state_type                   st,
   input  logic [7:0]                  own_node_id,
   input  req_item_type                req,
   output state_type                   st_next,
   output logic [1:0]                  rsp_count,
   output rsp_entry_type [MAX_RES-1:0] rsp_entry
);

   state_type                   nxt;
   rsp_entry_type [MAX_RES-1:0] res;
   logic [1:0]                  n;
   logic                        do_wake;
   logic                        do_data;
   logic                        do_end;
   logic                        reply_to;
   logic                        good_reply;
   logic [7:0]                  seq_inc;
   logic [7:0]                  dist_sel;

   assign good_reply = (req.rx_packet_kind == KIND_WAKE) && (req.rx_direction == DIR_UPSTREAM)
                       && ((req.rx_sender_type == NODE_REPEATER)
                           || (req.rx_sender_type == NODE_GATEWAY));

   always_comb begin
      nxt      = st;
      res      = '0;
      n        = '0;
      do_wake  = 1'b0;
      do_data  = 1'b0;
      do_end   = 1'b0;
      reply_to = 1'b0;
      seq_inc  = '0;
      dist_sel = '0;

      unique case (req.req_type)
         EV_TICK: begin
            if (st.phase == PH_IDLE) begin
               nxt.active     = 1'b1;
               nxt.retry_used = 1'b0;
               do_wake        = 1'b1;
            end
         end
         EV_TX_DONE: begin
            if (st.phase == PH_TXWAKE) begin
               nxt.phase = PH_WAIT;
               res[n]    = mk_entry(ACT_ARM, NOTE_NONE, '0, '0, '0, '0);
               n         = n + 2'd1;
            end else if (st.phase == PH_TXDATA) begin
               do_end = 1'b1;
            end else begin
               res[n] = mk_entry(ACT_SLEEP, NOTE_NONE, '0, '0, '0, '0);
               n      = n + 2'd1;
            end
         end
         EV_TX_TIMEOUT: begin
            if (st.phase == PH_TXWAKE) begin
               reply_to = 1'b1;
            end else begin
               do_end = 1'b1;
            end
         end
         EV_RX_FRAME: begin
            if (st.phase != PH_WAIT) begin
               res[n] = mk_entry(ACT_SLEEP, NOTE_NONE, '0, '0, '0, '0);
               n      = n + 2'd1;
            end else if (req.rx_header_ok && good_reply) begin
               res[n]                = mk_entry(ACT_SLEEP, NOTE_NONE, '0, '0, '0, '0);
               n                     = n + 2'd1;
               nxt.upstream_id       = req.rx_sender_id;
               nxt.upstream_distance = req.rx_sender_distance;
               nxt.upstream_type     = req.rx_sender_type;
               do_data               = 1'b1;
            end else begin
               res[n] = mk_entry(ACT_LISTEN, NOTE_NONE, '0, '0, '0, '0);
               n      = n + 2'd1;
            end
         end
         EV_RX_TIMEOUT, EV_REPLY_TIMER: begin
            if (st.phase == PH_WAIT) begin
               reply_to = 1'b1;
            end
         end
         EV_RX_ERROR: begin
            if (st.phase == PH_WAIT) begin
               res[n] = mk_entry(ACT_LISTEN, NOTE_NONE, '0, '0, '0, '0);
               n      = n + 2'd1;
            end else begin
               do_end = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // A missed reply to a known node retries once toward an unknown node, else the data is dropped.
      if (reply_to) begin
         res[n] = mk_entry(ACT_SLEEP, NOTE_NONE, '0, '0, '0, '0);
         n      = n + 2'd1;
         if ((nxt.upstream_id != 8'd0) && !nxt.retry_used) begin
            nxt.retry_used        = 1'b1;
            nxt.upstream_id       = '0;
            nxt.upstream_distance = '0;
            do_wake               = 1'b1;
         end else begin
            nxt.data_count = nxt.data_count + 16'd1;
            res[n]         = mk_entry(ACT_NOTICE, NOTE_DISCARDED, '0, '0, '0, '0);
            n              = n + 2'd1;
            do_end         = 1'b1;
         end
      end

      if (do_wake || do_data) begin
         if (req.queue_full) begin
            nxt.phase = PH_IDLE;
            res[n]    = mk_entry(ACT_NOTICE, NOTE_SKIPPED, '0, '0, '0, '0);
            n         = n + 2'd1;
            do_end    = 1'b1;
         end else begin
            seq_inc     = nxt.seq_num + 8'd1;
            nxt.seq_num = seq_inc;
            dist_sel    = (nxt.upstream_id != 8'd0) ? nxt.upstream_distance : 8'd0;
            if (do_data) begin
               nxt.data_count = nxt.data_count + 16'd1;
               nxt.phase      = PH_TXDATA;
               res[n] = mk_entry(ACT_DATA, NOTE_NONE, nxt.upstream_id, nxt.upstream_type,
                                 dist_sel, {own_node_id, seq_inc});
            end else begin
               nxt.phase = PH_TXWAKE;
               res[n] = mk_entry(ACT_WAKE, NOTE_NONE, nxt.upstream_id, NODE_REPEATER,
                                 dist_sel, {own_node_id, seq_inc});
            end
            n = n + 2'd1;
         end
      end

      if (do_end) begin
         nxt.phase      = PH_IDLE;
         nxt.retry_used = 1'b0;
         nxt.active     = 1'b0;
         res[n]         = mk_entry(ACT_SLEEP, NOTE_NONE, '0, '0, '0, '0);
         n              = n + 2'd1;
      end

      // Counter and activity are reported as they stand after the whole event.
      for (int k = 0; k < MAX_RES; k++) begin
         res[k].data_number  = nxt.data_count;
         res[k].cycle_active = nxt.active;
         res[k].last         = (2'(k) == (n - 2'd1));
      end
   end

   assign st_next   = nxt;
   assign rsp_count = n;
   assign rsp_entry = res;

endmodule

### src/wor_rsp_fifo.sv
// Result queue: takes up to three results of one event at once, hands out one per cycle while the output is ready.
// Depends on wor_pkg for the result entry type.
module wor_rsp_fifo
   import wor_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  push_count,
   input  rsp_entry_type [MAX_RES-1:0] push_data,
   output logic                        has_room,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rsp_entry_type               out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(DEPTH);

   rsp_entry_type      q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [PTR_W-1:0]   wr_idx [MAX_RES];
   logic [PTR_W:0]     wr_end;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= CNT_W'(DEPTH - MAX_RES));

   always_comb begin
      logic [PTR_W:0] sum;
      for (int k = 0; k < MAX_RES; k++) begin
         sum = {1'b0, wr_ptr_ff} + (PTR_W + 1)'(k);
         if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
         end
         wr_idx[k] = sum[PTR_W-1:0];
      end
   end

   always_comb begin
      wr_end = {1'b0, wr_ptr_ff} + (PTR_W + 1)'(push_count);
      if (wr_end >= DEPTH_EXT) begin
         wr_end = wr_end - DEPTH_EXT;
      end
      wr_ptr_in = wr_end[PTR_W-1:0];
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end else begin
         rd_ptr_in = rd_ptr_ff;
      end
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RES; k++) begin
         if (2'(k) < push_count) begin
            q_ff[wr_idx[k]] <= push_data[k];
         end
      end
   end

endmodule

### src/wake_on_radio_uplink_handshake.sv
// Uplink handshake controller of a wake-on-radio end device. One event transaction
// (tick, transmit or receive outcome, timer expiry) is accepted per clock cycle whenever
// the result queue has room for the up to three results an event can cause; the event
// is decoded and the state updated in that same cycle. Results leave the queue one per cycle while
// the output is ready; an event's first result is valid the cycle after acceptance if the queue was
// empty, else after earlier results, so the output drain rate sets the sustained event rate.
// Registers own_node_id (index 0, reset 1) and own_distance (index 1, no effect on results) are to be
// written by the user through the csr port only while idle; the block does not enforce this.
module wake_on_radio_uplink_handshake
   import wor_pkg::*;
#(
   parameter int RSP_DEPTH = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   wor_req_if.sink              req_ch,
   wor_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   state_type                   st_ff;
   state_type                   st_in;
   logic [7:0]                  own_node_id_ff;
   req_item_type                req_item;
   logic [1:0]                  step_count;
   rsp_entry_type [MAX_RES-1:0] step_entry;
   logic                        accept;
   logic                        has_room;
   rsp_entry_type               head;

   assign req_item = '{req_type:           req_ch.req_type,
                       queue_full:         req_ch.queue_full,
                       rx_header_ok:       req_ch.rx_header_ok,
                       rx_packet_kind:     req_ch.rx_packet_kind,
                       rx_direction:       req_ch.rx_direction,
                       rx_sender_type:     req_ch.rx_sender_type,
                       rx_sender_id:       req_ch.rx_sender_id,
                       rx_sender_distance: req_ch.rx_sender_distance};

   assign req_ch.ready = has_room;
   assign accept       = req_ch.valid && has_room;

   wor_step u_step (
      .st          (st_ff),
      .own_node_id (own_node_id_ff),
      .req         (req_item),
      .st_next     (st_in),
      .rsp_count   (step_count),
      .rsp_entry   (step_entry)
   );

   wor_rsp_fifo #(.DEPTH(RSP_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (accept ? step_count : 2'd0),
      .push_data  (step_entry),
      .has_room   (has_room),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (head)
   );

   assign rsp_ch.action         = head.action;
   assign rsp_ch.notice_code    = head.notice_code;
   assign rsp_ch.dest_node_id   = head.dest_node_id;
   assign rsp_ch.dest_node_type = head.dest_node_type;
   assign rsp_ch.dest_distance  = head.dest_distance;
   assign rsp_ch.frame_id       = head.frame_id;
   assign rsp_ch.data_number    = head.data_number;
   assign rsp_ch.cycle_active   = head.cycle_active;
   assign rsp_ch.last           = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase:             PH_IDLE,
                    retry_used:        1'b0,
                    upstream_id:       8'd0,
                    upstream_distance: 8'd0,
                    upstream_type:     NODE_REPEATER,
                    seq_num:           8'd0,
                    data_count:        16'd0,
                    active:            1'b0};
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   // The distance register has no effect on any result, so only the node number is kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_id_ff <= 8'd1;
      end else if (csr_we && (csr_index == CSR_OWN_NODE_ID)) begin
         own_node_id_ff <= csr_wdata;
      end
   end

endmodule

### src/wor_checker.sv
// Port-level checker for the uplink handshake controller, bound to the top level.
// Depends on wor_pkg and the assertion macros header.
`include "wake_on_radio_uplink_handshake_defines.svh"

module wor_checker
   import wor_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  action,
   input logic [1:0]  notice_code,
   input logic [7:0]  dest_node_id,
   input logic [1:0]  dest_node_type,
   input logic [7:0]  dest_distance,
   input logic [15:0] frame_id
);

   // A notice transaction always carries a reason, and no other transaction does.
   `WOR_ASSERT_SAME(a_notice_code, rsp_valid, (action == ACT_NOTICE) == (notice_code != 2'd0))

   // Addressing fields are only populated on wake and data frames.
   `WOR_ASSERT_SAME(a_addr_zero, rsp_valid && (action != ACT_WAKE) && (action != ACT_DATA), (dest_node_id == 8'd0) && (dest_node_type == 2'd0) && (dest_distance == 8'd0) && (frame_id == 16'd0))

   // An unknown upstream node never comes with a distance.
   `WOR_ASSERT_SAME(a_unknown_dist, rsp_valid && (dest_node_id == 8'd0), dest_distance == 8'd0)

   `WOR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(action) && $stable(frame_id))

endmodule

bind wake_on_radio_uplink_handshake wor_checker u_wor_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .action         (rsp_ch.action),
   .notice_code    (rsp_ch.notice_code),
   .dest_node_id   (rsp_ch.dest_node_id),
   .dest_node_type (rsp_ch.dest_node_type),
   .dest_distance  (rsp_ch.dest_distance),
   .frame_id       (rsp_ch.frame_id)
);
